[hdl/cmf_pkg.sv]
// Shared types and constants for the CAN message fragmenter.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package cmf_pkg;

   // Item opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_LEN = 2'd1;
   localparam logic [1:0] ST_BUSY    = 2'd2;

   // Frame layout
   localparam int         FRAG_PAYLOAD = 6;
   localparam int         SLOT_W       = 3;
   localparam logic [7:0] LAST_FLAG    = 8'h80;
   localparam logic [3:0] HEADER_BYTES = 4'd2;

   // Message store geometry
   localparam int STORE_DEPTH = 256;
   localparam int STORE_AW    = 8;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;      // item taken this cycle
      logic issue_read;  // read the next payload byte from the store
      logic finish;      // load the result register and commit the frame
   } cmf_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic frame_go;    // the offered item is a tick while a message goes out
      logic last_read;   // this read fetches the last payload byte
      logic out_free;    // the result register can take a new result
   } cmf_stat_type;

   // One result item
   typedef struct packed {
      logic [3:0] frame_length;
      logic [7:0] payload_5;
      logic [7:0] payload_4;
      logic [7:0] payload_3;
      logic [7:0] payload_2;
      logic [7:0] payload_1;
      logic [7:0] payload_0;
      logic [7:0] frame_index;
      logic [7:0] frame_sequence;
      logic       frame_valid;
      logic [1:0] status;
   } cmf_rsp_type;

endpackage

`default_nettype wire

[hdl/cmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hdl/cmf_ctrl.sv]
// Sequencing state machine of the CAN message fragmenter.
// Depends on cmf_pkg for the command and status structs.
`default_nettype none

module cmf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire cmf_pkg::cmf_stat_type stat,
   output cmf_pkg::cmf_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = stat.frame_go ? S_READ : S_DONE;
            end
         end
         S_READ: begin
            cmd.issue_read = 1'b1;
            if (stat.last_read) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // last byte lands in the payload registers
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/cmf_datapath.sv]
// Datapath of the CAN message fragmenter: message store, send state,
// payload gathering and the result register. Depends on cmf_pkg and cmf_ram.
`default_nettype none

module cmf_datapath #(
   parameter int MAX_MESSAGE_BYTES = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [1:0]            opcode,
   input  wire logic [7:0]            byte_position,
   input  wire logic [7:0]            data_byte,
   input  wire logic [9:0]            message_length,
   input  wire cmf_pkg::cmf_cmd_type  cmd,
   output cmf_pkg::cmf_stat_type      stat,
   input  wire logic                  rsp_tready,
   output logic                       rsp_valid,
   output cmf_pkg::cmf_rsp_type       rsp
);

   localparam logic [9:0] MAX_LEN = 10'(MAX_MESSAGE_BYTES);

   logic                           sending_ff,  sending_in;
   logic [9:0]                     length_ff,   length_in;
   logic [9:0]                     offset_ff,   offset_in;
   logic [7:0]                     sequence_ff, sequence_in;
   logic [7:0]                     frag_ff,     frag_in;
   logic [cmf_pkg::SLOT_W-1:0]     plen_ff,     plen_in;
   logic                           last_ff,     last_in;
   logic [cmf_pkg::SLOT_W-1:0]     slot_ff,     slot_in;
   logic                           rd_pend_ff,  rd_pend_in;
   logic [cmf_pkg::SLOT_W-1:0]     rd_slot_ff,  rd_slot_in;
   logic                           frame_ff,    frame_in;
   logic [1:0]                     status_ff,   status_in;
   logic [7:0]                     payload_ff [cmf_pkg::FRAG_PAYLOAD];
   logic [7:0]                     payload_in [cmf_pkg::FRAG_PAYLOAD];
   logic                           rsp_valid_ff, rsp_valid_in;
   cmf_pkg::cmf_rsp_type           rsp_ff,       rsp_in;

   logic [9:0]                 remaining;
   logic                       short_tail;
   logic                       store_we;
   logic [cmf_pkg::STORE_AW-1:0] rd_addr;
   logic [7:0]                 rd_data;

   assign remaining  = length_ff - offset_ff;
   assign short_tail = (remaining <= 10'(cmf_pkg::FRAG_PAYLOAD));
   assign store_we   = cmd.accept && (opcode == cmf_pkg::OP_LOAD) && !sending_ff;
   assign rd_addr    = offset_ff[cmf_pkg::STORE_AW-1:0]
                       + {{(cmf_pkg::STORE_AW-cmf_pkg::SLOT_W){1'b0}}, slot_ff};

   cmf_ram #(
      .WIDTH (8),
      .DEPTH (cmf_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (byte_position),
      .wr_data (data_byte),
      .rd_en   (cmd.issue_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.frame_go  = (opcode == cmf_pkg::OP_TICK) && sending_ff;
   assign stat.last_read = (slot_ff == plen_ff - 3'd1);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      sending_in   = sending_ff;
      length_in    = length_ff;
      offset_in    = offset_ff;
      sequence_in  = sequence_ff;
      frag_in      = frag_ff;
      plen_in      = plen_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      frame_in     = frame_ff;
      status_in    = status_ff;
      payload_in   = payload_ff;
      rd_pend_in   = cmd.issue_read;
      rd_slot_in   = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      if (cmd.accept) begin
         status_in = cmf_pkg::ST_OK;
         frame_in  = 1'b0;
         case (opcode)
            cmf_pkg::OP_LOAD: begin
               if (sending_ff) begin
                  status_in = cmf_pkg::ST_BUSY;
               end
            end
            cmf_pkg::OP_START: begin
               if (message_length == 10'd0 || message_length > MAX_LEN) begin
                  status_in = cmf_pkg::ST_BAD_LEN;
               end else if (sending_ff) begin
                  status_in = cmf_pkg::ST_BUSY;
               end else begin
                  length_in   = message_length;
                  offset_in   = 10'd0;
                  frag_in     = 8'd0;
                  sequence_in = sequence_ff + 8'd1;
                  sending_in  = 1'b1;
               end
            end
            cmf_pkg::OP_TICK: begin
               if (sending_ff) begin
                  frame_in   = 1'b1;
                  last_in    = short_tail;
                  plen_in    = short_tail ? remaining[cmf_pkg::SLOT_W-1:0]
                                          : cmf_pkg::SLOT_W'(cmf_pkg::FRAG_PAYLOAD);
                  slot_in    = '0;
                  for (int i = 0; i < cmf_pkg::FRAG_PAYLOAD; i++) begin
                     payload_in[i] = 8'd0;
                  end
               end
            end
            default: begin
               status_in = cmf_pkg::ST_OK;
            end
         endcase
      end

      if (cmd.issue_read) begin
         slot_in = slot_ff + 3'd1;
      end

      // registered store data arrives in the cycle after its read
      if (rd_pend_ff) begin
         payload_in[rd_slot_ff] = rd_data;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.status = status_ff;
         if (frame_ff) begin
            rsp_in.frame_valid    = 1'b1;
            rsp_in.frame_sequence = sequence_ff;
            rsp_in.frame_index    = last_ff ? (frag_ff | cmf_pkg::LAST_FLAG) : frag_ff;
            rsp_in.payload_0      = payload_ff[0];
            rsp_in.payload_1      = payload_ff[1];
            rsp_in.payload_2      = payload_ff[2];
            rsp_in.payload_3      = payload_ff[3];
            rsp_in.payload_4      = payload_ff[4];
            rsp_in.payload_5      = payload_ff[5];
            rsp_in.frame_length   = {1'b0, plen_ff} + cmf_pkg::HEADER_BYTES;
            offset_in = offset_ff + {7'd0, plen_ff};
            frag_in   = frag_ff + 8'd1;
            if (last_ff) begin
               sending_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff   <= 1'b0;
         length_ff    <= 10'd0;
         offset_ff    <= 10'd0;
         sequence_ff  <= 8'd0;
         frag_ff      <= 8'd0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sending_ff   <= sending_in;
         length_ff    <= length_in;
         offset_ff    <= offset_in;
         sequence_ff  <= sequence_in;
         frag_ff      <= frag_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plen_ff    <= plen_in;
      last_ff    <= last_in;
      slot_ff    <= slot_in;
      rd_slot_ff <= rd_slot_in;
      frame_ff   <= frame_in;
      status_ff  <= status_in;
      payload_ff <= payload_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

[hdl/can_message_fragmenter.sv]
// Top level of the CAN message fragmenter: stream ports, controller and datapath.
// Depends on cmf_pkg, cmf_ctrl, cmf_datapath (and through it cmf_ram).
//
// Usage:
//   The req channel carries one item per handshake: a load item writes one
//   byte into the 256-byte message store, a start item launches a message of
//   message_length bytes and bumps the 8-bit sequence number, a tick item
//   (one transmit mailbox free) pulls out the next CAN frame.
//   Every item yields exactly one rsp item: a status, and on ticks while a
//   message goes out a frame of sequence byte, fragment index (bit 7 marks
//   the last fragment), six payload bytes (zero past the end) and a length.
//   Loads and starts are refused as busy while a message goes out, a start
//   of 0 or over MAX_MESSAGE_BYTES bytes as a bad length. A frame reads its
//   plen payload bytes (plen = 1 to 6, one store read per cycle) before its
//   result; the next item is taken once the result is registered.
//   The rsp register holds a finished item while the receiver stalls; the
//   block still takes the next item and works on it, then waits until the
//   register drains before presenting the new result.
//   Reset clears the send state and sequence number and empties the result
//   register; the message store keeps whatever it held and must be loaded
//   before it is sent.
`default_nettype none

module can_message_fragmenter #(
   parameter int MAX_MESSAGE_BYTES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [7:0] byte_position, [15:8] data_byte, [25:16] message_length
   input  wire logic [31:0] req_tdata,
   // req_tuser: [1:0] opcode
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: [1:0] status, [9:2] frame_sequence, [17:10] frame_index,
   //   [25:18] payload_0, [33:26] payload_1, [41:34] payload_2,
   //   [49:42] payload_3, [57:50] payload_4, [65:58] payload_5,
   //   [69:66] frame_length, [71:70] zero
   output logic [71:0]      rsp_tdata,
   // rsp_tuser: [0] frame_valid
   output logic             rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);

   cmf_pkg::cmf_cmd_type  cmd;
   cmf_pkg::cmf_stat_type stat;
   cmf_pkg::cmf_rsp_type  rsp;

   // sequence the item: accept, gather payload bytes, present the result
   cmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // store, send state and result register
   cmf_datapath #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .opcode         (req_tuser),
      .byte_position  (req_tdata[7:0]),
      .data_byte      (req_tdata[15:8]),
      .message_length (req_tdata[25:16]),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp            (rsp)
   );

   // pack the result, lowest field first
   assign rsp_tdata = {2'b00,
                       rsp.frame_length,
                       rsp.payload_5,
                       rsp.payload_4,
                       rsp.payload_3,
                       rsp.payload_2,
                       rsp.payload_1,
                       rsp.payload_0,
                       rsp.frame_index,
                       rsp.frame_sequence,
                       rsp.status};
   assign rsp_tuser = rsp.frame_valid;

endmodule

`default_nettype wire

[hdl/cmf_checker.sv]
// Port-level checks for the CAN message fragmenter, bound to the top level.
// Depends on can_message_fragmenter port layout only.
`default_nettype none

module cmf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic        rsp_tuser,
   input wire logic [71:0] rsp_tdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // drop the result register at reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a result without a frame carries only its status
   a_no_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[71:2] == 70'd0)
      else $error("frame fields set on a result without a frame");

   // a frame always reports success
   a_frame_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == 2'd0)
      else $error("frame with nonzero status");

   // a frame carries one to six payload bytes plus the header
   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[69:66] >= 4'd3 && rsp_tdata[69:66] <= 4'd8)
      else $error("frame length out of range");

endmodule

bind can_message_fragmenter cmf_checker u_cmf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
